// File: hw/rtl/rca_pkg.sv
// Shared constants and types for the row circular autocorrelation block.
`default_nettype none

package rca_pkg;

	localparam int MAX_COLS_DEF     = 64;
	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int ROW_LENGTH_RESET = 64;

	localparam int CFG_W  = 7;
	localparam int LAG_W  = 6;
	localparam int CORR_W = 38;

	typedef enum logic {
		ST_LOAD,
		ST_CALC
	} rca_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/rca_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none

module rca_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/row_circular_autocorrelation.sv
// Row circular autocorrelation: row store, sequencer and one shared MAC unit.
//
// Usage: the samples of one row arrive on the sample channel (valid/stall),
// one per transfer, and are written into a row store. Once row_length (N)
// samples are in, the sample channel stalls and a single multiply-accumulate
// unit walks lags d = 0..N-1 and, for each, indices i = 0..N-1, one product
// per cycle unless the result receiver stalls. Each finished lag leaves on
// the result channel with lag, correlation and last_of_row (set for lag N-1).
// Throughput is set by the one MAC unit and the two read ports of the row
// store. Each result passes through the registered read data, the product
// register and the result register. Loading of the next row starts once
// the last product of the row has been issued, while the final results are
// still draining.
// When the result receiver stalls with a result waiting, the MAC pipeline
// and the sequencer freeze until that result is taken.
// Reset clears control state and sets row_length to its reset value; the
// row store is not cleared, as only samples of the current row are read.
// A write of row_length (while idle) discards any partial row.
`default_nettype none

module row_circular_autocorrelation #(
	parameter int MAX_COLS    = rca_pkg::MAX_COLS_DEF,
	parameter int SAMPLE_BITS = rca_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        row_length_we,
	input  wire logic [rca_pkg::CFG_W-1:0]   row_length,
	input  wire logic                        sample_valid,
	output logic                             sample_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic      [rca_pkg::LAG_W-1:0]   lag,
	output logic signed [rca_pkg::CORR_W-1:0] correlation,
	output logic                             last_of_row
);

	import rca_pkg::*;

	localparam int ADDR_W = $clog2(MAX_COLS);
	localparam int NW     = ADDR_W + 1;
	localparam int CMP_W  = (NW > CFG_W) ? NW : CFG_W;
	localparam int PW     = 2 * SAMPLE_BITS;
	localparam int ACC_W  = (PW + NW > CORR_W) ? PW + NW : CORR_W;
	localparam int DW     = (ADDR_W > LAG_W) ? ADDR_W : LAG_W;
	localparam int N_RST  = (ROW_LENGTH_RESET > MAX_COLS) ? MAX_COLS : ROW_LENGTH_RESET;

	rca_state_t state_q, state_d;

	logic [NW-1:0]     n_q;
	logic [ADDR_W-1:0] load_cnt_q;
	logic [ADDR_W-1:0] i_q;
	logic [ADDR_W-1:0] d_q;

	logic issue;
	logic adv;
	logic load_xfer;
	logic row_full;
	logic i_last;
	logic d_last;

	logic [CMP_W-1:0] cfg_ext;
	logic [CMP_W-1:0] cfg_sat;

	logic [NW-1:0]     j_sum;
	logic [NW-1:0]     j_wrap;
	logic [SAMPLE_BITS-1:0] rd_a;
	logic [SAMPLE_BITS-1:0] rd_b;

	logic              valid_s1, first_s1, lastlag_s1, lastrow_s1;
	logic [ADDR_W-1:0] d_s1;
	logic              valid_s2, first_s2, lastlag_s2, lastrow_s2;
	logic [ADDR_W-1:0] d_s2;
	logic signed [PW-1:0] prod_s2;
	logic signed [PW-1:0] a_ext;
	logic signed [PW-1:0] b_ext;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_sum;
	logic [DW-1:0]           lag_ext;

	logic                     out_valid_q;
	logic [LAG_W-1:0]         lag_q;
	logic signed [CORR_W-1:0] corr_q;
	logic                     last_q;

	// The whole MAC pipeline moves only when the result register can take a value.
	assign adv       = !out_valid_q || !result_stall;
	assign load_xfer = sample_valid && !sample_stall;
	assign row_full  = (NW'(load_cnt_q) + NW'(1)) == n_q;
	assign i_last    = (NW'(i_q) + NW'(1)) == n_q;
	assign d_last    = (NW'(d_q) + NW'(1)) == n_q;

	assign j_sum  = NW'(i_q) + NW'(d_q);
	assign j_wrap = (j_sum >= n_q) ? j_sum - n_q : j_sum;

	// Clamp the written row length to 1..MAX_COLS.
	assign cfg_ext = CMP_W'(row_length);
	always_comb begin
		if (cfg_ext == '0) begin
			cfg_sat = CMP_W'(1);
		end else if (cfg_ext > CMP_W'(MAX_COLS)) begin
			cfg_sat = CMP_W'(MAX_COLS);
		end else begin
			cfg_sat = cfg_ext;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (load_xfer && row_full) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (adv && i_last && d_last) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		sample_stall = 1'b1;
		issue        = 1'b0;
		case (state_q)
			ST_LOAD: sample_stall = 1'b0;
			ST_CALC: issue        = 1'b1;
			default: begin
				sample_stall = 1'b1;
				issue        = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			n_q        <= NW'(N_RST);
			load_cnt_q <= '0;
			i_q        <= '0;
			d_q        <= '0;
		end else begin
			state_q <= state_d;
			if (row_length_we) begin
				n_q        <= NW'(cfg_sat);
				load_cnt_q <= '0;
			end else if (load_xfer) begin
				load_cnt_q <= row_full ? '0 : load_cnt_q + ADDR_W'(1);
			end
			if (issue && adv) begin
				if (i_last) begin
					i_q <= '0;
					d_q <= d_last ? '0 : d_q + ADDR_W'(1);
				end else begin
					i_q <= i_q + ADDR_W'(1);
				end
			end
		end
	end

	rca_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_COLS)
	) u_row_store (
		.clk    (clk),
		.we     (load_xfer),
		.waddr  (load_cnt_q),
		.wdata  (sample),
		.re     (adv),
		.raddr_a(i_q),
		.raddr_b(j_wrap[ADDR_W-1:0]),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	// Stage 1 tags travel beside the registered read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	assign a_ext = PW'($signed(rd_a));
	assign b_ext = PW'($signed(rd_b));

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1   <= (i_q == '0);
			lastlag_s1 <= i_last;
			lastrow_s1 <= d_last;
			d_s1       <= d_q;
			first_s2   <= first_s1;
			lastlag_s2 <= lastlag_s1;
			lastrow_s2 <= lastrow_s1;
			d_s2       <= d_s1;
			prod_s2    <= a_ext * b_ext;
		end
	end

	assign acc_sum = (first_s2 ? '0 : acc_q) + ACC_W'(prod_s2);
	assign lag_ext = DW'(d_s2);

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			acc_q <= acc_sum;
		end
		if (adv && valid_s2 && lastlag_s2) begin
			lag_q  <= lag_ext[LAG_W-1:0];
			corr_q <= acc_sum[CORR_W-1:0];
			last_q <= lastrow_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2 && lastlag_s2;
		end
	end

	assign result_valid = out_valid_q;
	assign lag          = lag_q;
	assign correlation  = corr_q;
	assign last_of_row  = last_q;

	a_calc_no_partial: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC |-> load_cnt_q == '0)
		else $error("partial row count while computing");

	a_calc_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC |-> (NW'(i_q) < n_q) && (NW'(d_q) < n_q))
		else $error("MAC index beyond row length");

	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && valid_s2 |=> valid_s2 && $stable(prod_s2))
		else $error("pipeline moved while result was stalled");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s2 && lastlag_s2 |=> result_valid)
		else $error("finished lag not presented");

endmodule

`default_nettype wire
